// ===== rtl/dsat_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, rank request and result structs and the free-color search for the DSatur core.
// Depends on nothing; every other file imports it.

package dsat_pkg;

    localparam int ROW_SLOTS        = 32;
    localparam int MAX_VERTICES_DEF = 32;
    localparam int IDX_W            = 5;
    localparam int COLOR_W          = 5;
    localparam int CNT_W            = 6;
    localparam int SET_W            = 32;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 6'd32;

    typedef struct packed {
        logic [SET_W-1:0] word;
        logic [CNT_W-1:0] deg;
        logic [CNT_W-1:0] best_cnt;
        logic [CNT_W-1:0] best_deg;
        logic             found;
    } rank_req_t;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             better;
    } rank_res_t;

    // lowest color not in the set, capped at the top color
    function automatic logic [COLOR_W-1:0] low_free(input logic [SET_W-1:0] s);
        logic [COLOR_W-1:0] c;
        c = COLOR_W'(SET_W - 1);
        for (int i = SET_W - 2; i >= 0; i--)
        begin
            if (!s[i])
            begin
                c = COLOR_W'(i);
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/dsat_rank.sv =====
`timescale 1ns / 1ps
// Shared count-and-compare unit: popcount of one word, ranked against the best so far.
// Depends on dsat_pkg.

module dsat_rank (
    input  dsat_pkg::rank_req_t req,
    output dsat_pkg::rank_res_t res
);
    import dsat_pkg::*;

    localparam int NIB = SET_W / 4;

    logic [2:0]       nib_cnt [NIB];
    logic [CNT_W-1:0] total;

    always_comb
    begin
        for (int i = 0; i < NIB; i++)
        begin
            nib_cnt[i] = 3'(req.word[4*i])   + 3'(req.word[4*i+1])
                       + 3'(req.word[4*i+2]) + 3'(req.word[4*i+3]);
        end
        total = '0;
        for (int i = 0; i < NIB; i++)
        begin
            total = total + CNT_W'(nib_cnt[i]);
        end
    end

    assign res.cnt    = total;
    assign res.better = !req.found || (total > req.best_cnt)
                     || ((total == req.best_cnt) && (req.deg > req.best_deg));

endmodule

// ===== rtl/dsatur_graph_coloring_core.sv =====
`timescale 1ns / 1ps
// DSatur graph coloring core: row store, sequencer around one shared rank unit, result port.
// Depends on dsat_pkg and dsat_rank.
//
//   channel   direction  handshake               word
//   cfg       in         cfg_wr_en               cfg_wr_data (node_count)
//   in        in         in_valid / in_ready     row_index, row_bits, last_row
//   out       out        out_valid / out_ready   vertex, color, color_count, last
//
// An ordinary row is taken while idle. A last row starts a run: a degree count over
// all n vertices, then n-1 scans over all n vertices, plus one paint per vertex,
// then n words out; the single rank unit walks all vertices in each pass.
// Reset is asynchronous and clears control state; in_ready is high only while idle.
// A stall on out holds the current word and the sequencer.

module dsatur_graph_coloring_core #(
    parameter int MAX_VERTICES = dsat_pkg::MAX_VERTICES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [dsat_pkg::CNT_W-1:0]   cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [dsat_pkg::IDX_W-1:0]   row_index,
    input  logic [dsat_pkg::SET_W-1:0]   row_bits,
    input  logic                         last_row,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dsat_pkg::IDX_W-1:0]   vertex,
    output logic [dsat_pkg::COLOR_W-1:0] color,
    output logic [dsat_pkg::CNT_W-1:0]   color_count,
    output logic                         last
);
    import dsat_pkg::*;

    localparam int NV = (MAX_VERTICES < ROW_SLOTS) ? MAX_VERTICES : ROW_SLOTS;
    localparam int VW = $clog2(NV);
    localparam int NW = VW + 1;
    localparam logic [IDX_W:0] NV_EXT = (IDX_W + 1)'(NV);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_PAINT,
        ST_EMIT
    } state_t;

    state_t state_reg;

    logic [CNT_W-1:0]   node_count_reg;
    logic [NW-1:0]      n_reg;
    logic [NV-1:0]      row_valid_reg;
    logic [NV-1:0]      colored_reg;
    logic [VW-1:0]      idx_reg;
    logic [NW-1:0]      done_reg;
    logic               found_reg;

    logic [NV-1:0]      adj_mem   [NV];
    logic [CNT_W-1:0]   deg_mem   [NV];
    logic [SET_W-1:0]   set_mem   [NV];
    logic [COLOR_W-1:0] color_mem [NV];

    logic [VW-1:0]      best_idx_reg;
    logic [CNT_W-1:0]   best_cnt_reg;
    logic [CNT_W-1:0]   best_deg_reg;
    logic [NV-1:0]      best_row_reg;
    logic [SET_W-1:0]   best_set_reg;
    logic [COLOR_W-1:0] max_color_reg;

    logic               out_valid_reg;
    logic [VW-1:0]      emit_idx_reg;
    logic [IDX_W-1:0]   vertex_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               last_reg;

    logic               accept_in;
    logic               load_row;
    logic               start_run;
    logic [NW-1:0]      n_clamp;
    logic [NV-1:0]      lim_mask;
    logic [NV-1:0]      scan_row;
    logic [NV-1:0]      prep_row;
    logic               idx_last;
    logic               take;
    logic [COLOR_W-1:0] paint_color;
    logic               paint_done;
    logic               emit_start;
    logic               out_fire;
    logic               emit_load;
    logic [VW-1:0]      ld_idx;
    rank_req_t          rank_req;
    rank_res_t          rank_res;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept_in = in_valid && in_ready;
    assign load_row  = accept_in && ({1'b0, row_index} < NV_EXT);
    assign start_run = accept_in && last_row;

    assign n_clamp = (node_count_reg == '0) ? NW'(1)
                   : (node_count_reg > CNT_W'(NV)) ? NW'(NV)
                   : NW'(node_count_reg);

    always_comb
    begin
        for (int j = 0; j < NV; j++)
        begin
            lim_mask[j] = (NW'(j) < n_reg);
        end
    end

    assign scan_row = row_valid_reg[idx_reg] ? adj_mem[idx_reg] : '0;
    assign prep_row = scan_row & lim_mask & ~(NV'(1) << idx_reg);
    assign idx_last = (NW'(idx_reg) == (n_reg - NW'(1)));

    always_comb
    begin
        rank_req.best_cnt = best_cnt_reg;
        rank_req.best_deg = best_deg_reg;
        rank_req.found    = found_reg;
        if (state_reg == ST_PREP)
        begin
            rank_req.word = SET_W'(prep_row);
            rank_req.deg  = '0;
        end
        else
        begin
            rank_req.word = set_mem[idx_reg];
            rank_req.deg  = deg_mem[idx_reg];
        end
    end

    dsat_rank u_rank (
        .req (rank_req),
        .res (rank_res)
    );

    assign take = rank_res.better
               && ((state_reg == ST_PREP)
                   || ((state_reg == ST_SCAN) && !colored_reg[idx_reg]));

    assign paint_color = low_free(best_set_reg);
    assign paint_done  = ((done_reg + NW'(1)) == n_reg);
    assign emit_start  = (state_reg == ST_PAINT) && paint_done;

    assign out_fire  = out_valid_reg && out_ready;
    assign emit_load = (state_reg == ST_EMIT)
                    && (!out_valid_reg || (out_fire && !last_reg));
    assign ld_idx    = out_valid_reg ? (emit_idx_reg + VW'(1)) : emit_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= NODE_COUNT_RST;
            row_valid_reg  <= '0;
            colored_reg    <= '0;
            idx_reg        <= '0;
            done_reg       <= '0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                node_count_reg <= cfg_wr_data;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (load_row)
                    begin
                        row_valid_reg[row_index[VW-1:0]] <= 1'b1;
                    end
                    if (start_run)
                    begin
                        state_reg   <= ST_PREP;
                        colored_reg <= '0;
                        idx_reg     <= '0;
                        done_reg    <= '0;
                        found_reg   <= 1'b0;
                    end
                end
                ST_PREP, ST_SCAN:
                begin
                    if (take)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (idx_last)
                    begin
                        state_reg <= ST_PAINT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + VW'(1);
                    end
                end
                ST_PAINT:
                begin
                    colored_reg[best_idx_reg] <= 1'b1;
                    done_reg                  <= done_reg + NW'(1);
                    idx_reg                   <= '0;
                    found_reg                 <= 1'b0;
                    if (paint_done)
                    begin
                        state_reg     <= ST_EMIT;
                        row_valid_reg <= '0;
                        out_valid_reg <= 1'b0;
                    end
                    else
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_load)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                    else if (out_fire && last_reg)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_row)
        begin
            adj_mem[row_index[VW-1:0]] <= row_bits[NV-1:0];
        end
        if (start_run)
        begin
            n_reg         <= n_clamp;
            max_color_reg <= '0;
        end
        if (state_reg == ST_PREP)
        begin
            adj_mem[idx_reg] <= prep_row;
            deg_mem[idx_reg] <= rank_res.cnt;
            set_mem[idx_reg] <= '0;
        end
        if (take)
        begin
            best_idx_reg <= idx_reg;
            best_cnt_reg <= rank_res.cnt;
            best_deg_reg <= rank_req.deg;
            best_row_reg <= (state_reg == ST_PREP) ? prep_row : scan_row;
            best_set_reg <= (state_reg == ST_PREP) ? '0 : set_mem[idx_reg];
        end
        if (state_reg == ST_PAINT)
        begin
            color_mem[best_idx_reg] <= paint_color;
            if (paint_color > max_color_reg)
            begin
                max_color_reg <= paint_color;
            end
            for (int j = 0; j < NV; j++)
            begin
                if (best_row_reg[j])
                begin
                    set_mem[j][paint_color] <= 1'b1;
                end
            end
        end
        if (emit_start)
        begin
            emit_idx_reg <= '0;
        end
        else if (emit_load)
        begin
            emit_idx_reg <= ld_idx;
            vertex_reg   <= IDX_W'(ld_idx);
            color_reg    <= color_mem[ld_idx];
            count_reg    <= CNT_W'(max_color_reg) + CNT_W'(1);
            last_reg     <= (NW'(ld_idx) == (n_reg - NW'(1)));
        end
    end

    assign out_valid   = out_valid_reg;
    assign vertex      = vertex_reg;
    assign color       = color_reg;
    assign color_count = count_reg;
    assign last        = last_reg;

endmodule

// ===== rtl/dsat_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the DSatur core, bound onto the top level.
// Depends on dsat_pkg and dsatur_graph_coloring_core.

module dsat_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [dsat_pkg::IDX_W-1:0]   vertex,
    input logic [dsat_pkg::COLOR_W-1:0] color,
    input logic [dsat_pkg::CNT_W-1:0]   color_count,
    input logic                         last
);
    import dsat_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(vertex) && $stable(color)
            && $stable(color_count) && $stable(last))
        else $error("out word changed while stalled");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input taken while results pending");

    a_vertex_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid
            && (vertex == ($past(vertex) + IDX_W'(1))))
        else $error("result vertices out of order");

    a_color_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, color} < color_count))
        else $error("color not below color count");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> !out_valid && in_ready)
        else $error("block not idle after final result");

endmodule

bind dsatur_graph_coloring_core dsat_checker u_dsat_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .vertex      (vertex),
    .color       (color),
    .color_count (color_count),
    .last        (last)
);

// ===== dv/tb_dsatur_graph_coloring_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for dsatur_graph_coloring_core: loads graphs row by row, colors them
// with its own DSatur predictor and checks every result word. Depends on dsat_pkg and the core.

module tb_dsatur_graph_coloring_core;

    import dsat_pkg::*;

    localparam int unsigned RUN_LIMIT = 5000000;

    typedef struct {
        logic [IDX_W-1:0]   vertex;
        logic [COLOR_W-1:0] color;
        logic [CNT_W-1:0]   color_count;
        logic               last;
    } coloring_word_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [CNT_W-1:0]    cfg_wr_data;
    logic                in_valid;
    logic                in_ready;
    logic [IDX_W-1:0]    row_index;
    logic [SET_W-1:0]    row_bits;
    logic                last_row;
    logic                out_valid;
    logic                out_ready;
    logic [IDX_W-1:0]    vertex;
    logic [COLOR_W-1:0]  color;
    logic [CNT_W-1:0]    color_count;
    logic                last;

    logic [SET_W-1:0]    adj_store [ROW_SLOTS];
    logic [CNT_W-1:0]    node_count_q;
    coloring_word_t      expected_words [$];
    int                  send_idle_pct;
    int                  recv_idle_pct;
    bit                  failed = 1'b0;
    int unsigned         cycle_count = 0;

    dsatur_graph_coloring_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .row_index   (row_index),
        .row_bits    (row_bits),
        .last_row    (last_row),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .vertex      (vertex),
        .color       (color),
        .color_count (color_count),
        .last        (last)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic int active_vertices();
        int n;
        n = int'(node_count_q);
        if (n == 0)
            n = 1;
        if (n > ROW_SLOTS)
            n = ROW_SLOTS;
        return n;
    endfunction

    function automatic void predict_coloring();
        int n;
        logic [SET_W-1:0] keep;
        logic [SET_W-1:0] nbr [ROW_SLOTS];
        logic [SET_W-1:0] seen [ROW_SLOTS];
        int degree [ROW_SLOTS];
        int paint [ROW_SLOTS];
        logic [SET_W-1:0] painted;
        int pick;
        int pick_sat;
        int sat;
        int c;
        int top;
        coloring_word_t w;
        n = active_vertices();
        keep = (n == SET_W) ? '1 : ((SET_W'(1) << n) - SET_W'(1));
        painted = '0;
        for (int v = 0; v < n; v++)
        begin
            nbr[v] = adj_store[v] & keep & ~(SET_W'(1) << v);
            degree[v] = $countones(nbr[v]);
            seen[v] = '0;
        end
        for (int step = 0; step < n; step++)
        begin
            pick = -1;
            pick_sat = 0;
            if (step == 0)
            begin
                pick = 0;
                for (int v = 1; v < n; v++)
                    if (degree[v] > degree[pick])
                        pick = v;
            end
            else
            begin
                for (int v = 0; v < n; v++)
                begin
                    if (!painted[v])
                    begin
                        sat = $countones(seen[v]);
                        if (pick < 0 || sat > pick_sat ||
                            (sat == pick_sat && degree[v] > degree[pick]))
                        begin
                            pick = v;
                            pick_sat = sat;
                        end
                    end
                end
            end
            c = 0;
            while (c < SET_W - 1 && seen[pick][c])
                c++;
            paint[pick] = c;
            painted[pick] = 1'b1;
            for (int j = 0; j < n; j++)
                if (nbr[pick][j])
                    seen[j][c] = 1'b1;
        end
        top = 0;
        for (int v = 0; v < n; v++)
            if (paint[v] > top)
                top = paint[v];
        for (int v = 0; v < n; v++)
        begin
            w.vertex = IDX_W'(v);
            w.color = COLOR_W'(paint[v]);
            w.color_count = CNT_W'(top + 1);
            w.last = (v == n - 1);
            expected_words.insert(expected_words.size(), w);
        end
        for (int v = 0; v < ROW_SLOTS; v++)
            adj_store[v] = '0;
    endfunction

    always @(posedge clk)
    begin
        coloring_word_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: vertex %0d color %0d", vertex, color);
                failed = 1'b1;
            end
            else
            begin
                w = expected_words.pop_front();
                if (vertex !== w.vertex)
                begin
                    $error("vertex: expected %0d, actual %0d", w.vertex, vertex);
                    failed = 1'b1;
                end
                if (color !== w.color)
                begin
                    $error("color: expected %0d, actual %0d", w.color, color);
                    failed = 1'b1;
                end
                if (color_count !== w.color_count)
                begin
                    $error("color_count: expected %0d, actual %0d", w.color_count, color_count);
                    failed = 1'b1;
                end
                if (last !== w.last)
                begin
                    $error("last: expected %0d, actual %0d", w.last, last);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic send_row(input logic [IDX_W-1:0] idx, input logic [SET_W-1:0] bits,
                            input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        row_index <= idx;
        row_bits <= bits;
        last_row <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        adj_store[idx] = bits;
        if (fin)
            predict_coloring();
    endtask

    // drop valid, hold until every word is back, then let the core settle
    task automatic wait_results_idle();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_node_count(input logic [CNT_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        node_count_q = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_reset_node_count();
        send_row(IDX_W'(0), '1, 1'b1);
        wait_results_idle();
    endtask

    task automatic test_node_count_clamp();
        set_node_count(CNT_W'(0));
        send_row(IDX_W'(5), '1, 1'b1);
        wait_results_idle();
        set_node_count(CNT_W'(63));
        send_row(IDX_W'(31), '1, 1'b1);
        wait_results_idle();
        set_node_count(CNT_W'(1));
        send_row(IDX_W'(0), '1, 1'b1);
        wait_results_idle();
    endtask

    task automatic test_row_rules();
        set_node_count(CNT_W'(5));
        send_row(IDX_W'(2), $urandom, 1'b0);
        send_row(IDX_W'(2), 32'h0000_0019, 1'b0);
        send_row(IDX_W'(9), '1, 1'b0);
        send_row(IDX_W'(0), '1, 1'b0);
        send_row(IDX_W'(3), 32'h0000_0001, 1'b0);
        send_row(IDX_W'(4), '0, 1'b1);
        wait_results_idle();
    endtask

    task automatic test_complete_and_empty();
        set_node_count(CNT_W'(4));
        for (int i = 0; i < 4; i++)
            send_row(IDX_W'(i), 32'h0000_000F, i == 3);
        wait_results_idle();
        set_node_count(CNT_W'(32));
        send_row(IDX_W'(31), '0, 1'b1);
        wait_results_idle();
    endtask

    task automatic test_random_graphs(input int send_pct, input int recv_pct, input int budget);
        int sent;
        int n;
        int r;
        int kind;
        int density;
        int k;
        int j;
        int tmp;
        int idx;
        logic [SET_W-1:0] keep;
        logic [SET_W-1:0] mat [ROW_SLOTS];
        int order [ROW_SLOTS];
        logic [CNT_W-1:0] cnt;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(2) == 0)
            begin
                wait_results_idle();
                r = $urandom_range(19);
                if (r < 12)
                    cnt = CNT_W'($urandom_range(8, 1));
                else if (r < 14)
                    cnt = CNT_W'(32);
                else if (r == 14)
                    cnt = CNT_W'(0);
                else if (r == 15)
                    cnt = CNT_W'($urandom_range(63, 33));
                else
                    cnt = CNT_W'($urandom_range(31, 9));
                set_node_count(cnt);
            end
            n = active_vertices();
            keep = (n == SET_W) ? '1 : ((SET_W'(1) << n) - SET_W'(1));
            kind = $urandom_range(9);
            if (kind == 0)
            begin
                k = $urandom_range(6, 1);
                for (int i = 0; i < k; i++)
                begin
                    idx = $urandom_range(31);
                    send_row(IDX_W'(idx), $urandom, (i == k - 1) ? 1'($urandom_range(1)) : 1'b0);
                    sent++;
                end
            end
            else
            begin
                density = (kind == 1) ? 100 : (kind == 2) ? 0 : $urandom_range(100);
                for (int i = 0; i < n; i++)
                    mat[i] = '0;
                for (int i = 0; i < n; i++)
                    for (int c = i + 1; c < n; c++)
                        if ($urandom_range(99) < density)
                        begin
                            mat[i][c] = 1'b1;
                            mat[c][i] = 1'b1;
                        end
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(3) == 0)
                        mat[i] = mat[i] | ($urandom & ~keep) |
                                 (SET_W'($urandom_range(1)) << i);
                    order[i] = i;
                end
                for (int i = n - 1; i > 0; i--)
                begin
                    j = $urandom_range(i);
                    tmp = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                for (int i = 0; i < n; i++)
                begin
                    if (n < ROW_SLOTS && $urandom_range(7) == 0)
                    begin
                        send_row(IDX_W'($urandom_range(31, n)), $urandom, 1'b0);
                        sent++;
                    end
                    if (i == n - 1 || (mat[order[i]] & keep) != '0 || $urandom_range(1) == 0)
                    begin
                        send_row(IDX_W'(order[i]), mat[order[i]], i == n - 1);
                        sent++;
                    end
                end
            end
        end
        wait_results_idle();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        in_valid <= 1'b0;
        row_index <= '0;
        row_bits <= '0;
        last_row <= 1'b0;
        node_count_q = NODE_COUNT_RST;
        for (int v = 0; v < ROW_SLOTS; v++)
            adj_store[v] = '0;
        send_idle_pct = 21;
        recv_idle_pct = 69;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_node_count();
        test_node_count_clamp();
        test_row_rules();
        test_complete_and_empty();
        test_random_graphs(21, 69, 170);
        test_random_graphs(69, 21, 170);
        test_random_graphs(0, 0, 170);

        wait_results_idle();
        repeat (50) @(posedge clk);
        if (!failed)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
